>>> rtl/core/dsc_pkg.sv
`timescale 1ns / 1ps

package dsc_pkg;

  // Fixed field widths of one transaction on each channel.
  localparam int unsigned OpcodeW = 2;
  localparam int unsigned SymbolW = 8;
  localparam int unsigned OutCountW = 64;

  // Operation codes carried in the opcode field.
  localparam logic [OpcodeW-1:0] OP_CLEAR = 2'd0;
  localparam logic [OpcodeW-1:0] OP_APPEND = 2'd1;
  localparam logic [OpcodeW-1:0] OP_TEXT = 2'd2;
  localparam logic [OpcodeW-1:0] OP_REPORT = 2'd3;

  // Input transaction.
  typedef struct packed {
    logic [OpcodeW-1:0] opcode;
    logic [SymbolW-1:0] symbol;
  } in_t;

  // Result transaction.
  typedef struct packed {
    logic [OutCountW-1:0] occurrence_count;
    logic                 count_saturated;
    logic                 pattern_overflow;
  } out_t;

endpackage

>>> rtl/core/distinct_subsequence_counter.sv
`timescale 1ns / 1ps
// Clear and append complete without leaving the idle state. A text symbol walks the L
// prefix counts of the pattern upward, one prefix count per cycle through the shared
// saturating adder and the single read port of the entry RAM. A report waits in the
// report state until the output register is free. One transaction is in work at a time.
// Reset clears the control state and flags; RAM contents are not cleared.

module distinct_subsequence_counter #(
  parameter int unsigned MAX_PATTERN = 128,
  parameter int unsigned COUNT_BITS = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  dsc_pkg::in_t              in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output dsc_pkg::out_t             out_data_o
);

  localparam int unsigned AddrW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned LenW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned EntryW = dsc_pkg::SymbolW + COUNT_BITS;
  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_PATTERN);
  localparam logic [COUNT_BITS-1:0] CountMax = '1;
  localparam logic [COUNT_BITS-1:0] CountOne = COUNT_BITS'(1);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_REPORT = 2'd2;

  logic [1:0] state_q, state_d;
  logic [LenW-1:0] len_q, len_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [COUNT_BITS-1:0] prev_q, prev_d;
  logic [dsc_pkg::SymbolW-1:0] sym_q, sym_d;
  logic sat_q, sat_d;
  logic ovf_q, ovf_d;
  logic out_valid_q, out_valid_d;
  dsc_pkg::out_t out_data_q, out_data_d;

  logic ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [EntryW-1:0] ram_wdata;
  logic ram_re;
  logic [AddrW-1:0] ram_raddr;
  logic [EntryW-1:0] ram_rdata;

  logic in_accept;
  logic [dsc_pkg::SymbolW-1:0] ent_sym;
  logic [COUNT_BITS-1:0] ent_cnt;
  logic [COUNT_BITS:0] sum_w;
  logic [COUNT_BITS-1:0] upd_cnt;
  logic [LenW-1:0] next_idx_w;
  logic [LenW-1:0] last_idx_w;

  // Pattern symbol and its prefix count share one RAM entry; entry k-1 holds count k.
  dsc_ram #(
    .WIDTH (EntryW),
    .DEPTH (MAX_PATTERN),
    .ADDR_W(AddrW)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept = in_valid_i && !in_stall_o;

  // Shared saturating adder: count k gains the old count k-1 on a symbol match.
  assign ent_sym = ram_rdata[EntryW-1:COUNT_BITS];
  assign ent_cnt = ram_rdata[COUNT_BITS-1:0];
  assign sum_w = {1'b0, ent_cnt} + {1'b0, prev_q};
  assign upd_cnt = (ent_sym != sym_q) ? ent_cnt :
                   (sum_w[COUNT_BITS] ? CountMax : sum_w[COUNT_BITS-1:0]);
  assign next_idx_w = LenW'(idx_q) + LenW'(1);
  assign last_idx_w = len_q - LenW'(1);

  // Sequencer and datapath control.
  always_comb begin
    state_d = state_q;
    len_d = len_q;
    idx_d = idx_q;
    prev_d = prev_q;
    sym_d = sym_q;
    sat_d = sat_q;
    ovf_d = ovf_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d = out_data_q;
    ram_we = 1'b0;
    ram_waddr = len_q[AddrW-1:0];
    ram_wdata = {in_data_i.symbol, {COUNT_BITS{1'b0}}};
    ram_re = 1'b0;
    ram_raddr = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (in_data_i.opcode)
            dsc_pkg::OP_CLEAR: begin
              len_d = '0;
              sat_d = 1'b0;
              ovf_d = 1'b0;
            end
            dsc_pkg::OP_APPEND: begin
              if (len_q < MaxLen) begin
                ram_we = 1'b1;
                len_d = len_q + LenW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            dsc_pkg::OP_TEXT: begin
              // Walk prefixes upward; count 0 is the constant one.
              if (len_q != '0) begin
                ram_re = 1'b1;
                idx_d = '0;
                prev_d = CountOne;
                sym_d = in_data_i.symbol;
                state_d = ST_WALK;
              end
            end
            dsc_pkg::OP_REPORT: begin
              ram_re = (len_q != '0);
              ram_raddr = last_idx_w[AddrW-1:0];
              state_d = ST_REPORT;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_WALK: begin
        // Write back this entry while reading the next one.
        ram_we = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = {ent_sym, upd_cnt};
        if ((ent_sym == sym_q) && sum_w[COUNT_BITS]) begin
          sat_d = 1'b1;
        end
        prev_d = ent_cnt;
        if (next_idx_w == len_q) begin
          state_d = ST_IDLE;
        end else begin
          ram_re = 1'b1;
          ram_raddr = next_idx_w[AddrW-1:0];
          idx_d = next_idx_w[AddrW-1:0];
        end
      end
      ST_REPORT: begin
        // Load the output register once the previous result has left.
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_data_d.occurrence_count =
            dsc_pkg::OutCountW'((len_q == '0) ? CountOne : ent_cnt);
          out_data_d.count_saturated = sat_q;
          out_data_d.pattern_overflow = ovf_q;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len_q <= '0;
      sat_q <= 1'b0;
      ovf_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q <= len_d;
      sat_q <= sat_d;
      ovf_q <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    prev_q <= prev_d;
    sym_q <= sym_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_data_q;

endmodule

>>> rtl/core/dsc_ram.sv
`timescale 1ns / 1ps

module dsc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port; read data holds between reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> dv/distinct_subsequence_counter_tb.sv
`timescale 1ns / 1ps

module distinct_subsequence_counter_tb;

  localparam int unsigned MaxPattern = 128;
  localparam int unsigned CountBits = 64;
  localparam int unsigned MaxGap = 10;
  localparam int unsigned RandomItems = 600;
  // The drain outlasts a text symbol walking a full pattern.
  localparam int unsigned DrainCycles = MaxPattern + 40;
  localparam int unsigned CycleLimit = 400000;

  typedef enum int unsigned {
    CaseTypical,
    CaseSaturate,
    CaseOverflow,
    CaseNoise
  } case_kind_e;

  // Tracks the expected pattern, prefix counts and flags, and holds the reports still owed.
  class occurrence_scoreboard;
    logic [dsc_pkg::SymbolW-1:0] pattern_sym [MaxPattern];
    logic [dsc_pkg::OutCountW-1:0] prefix_cnt [MaxPattern+1];
    int unsigned pattern_len;
    bit sat_seen;
    bit ovf_seen;
    dsc_pkg::out_t owed_reports [$];
    int unsigned errors;

    function new();
      errors = 0;
      clear_case();
    endfunction

    function void clear_case();
      foreach (pattern_sym[i]) pattern_sym[i] = '0;
      foreach (prefix_cnt[i]) prefix_cnt[i] = '0;
      prefix_cnt[0] = dsc_pkg::OutCountW'(1);
      pattern_len = 0;
      sat_seen = 1'b0;
      ovf_seen = 1'b0;
    endfunction

    // Sums clamp at the all-ones count and leave the saturation flag set.
    function logic [dsc_pkg::OutCountW-1:0] add_sat(logic [dsc_pkg::OutCountW-1:0] a,
                                                    logic [dsc_pkg::OutCountW-1:0] b);
      logic [dsc_pkg::OutCountW:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum[CountBits]) begin
        sat_seen = 1'b1;
        return '1;
      end
      return sum[dsc_pkg::OutCountW-1:0];
    endfunction

    // Applies one accepted input transaction to the predicted state.
    function void note_transaction(dsc_pkg::in_t t);
      dsc_pkg::out_t rep;
      case (t.opcode)
        dsc_pkg::OP_CLEAR: begin
          clear_case();
        end
        dsc_pkg::OP_APPEND: begin
          if (pattern_len < MaxPattern) begin
            pattern_sym[pattern_len] = t.symbol;
            pattern_len++;
            prefix_cnt[pattern_len] = '0;
          end else begin
            ovf_seen = 1'b1;
          end
        end
        dsc_pkg::OP_TEXT: begin
          // Walk from the top so each position adds the old count below it.
          for (int k = pattern_len; k >= 1; k--) begin
            if (pattern_sym[k-1] == t.symbol) begin
              prefix_cnt[k] = add_sat(prefix_cnt[k], prefix_cnt[k-1]);
            end
          end
        end
        default: begin
          rep.occurrence_count = prefix_cnt[pattern_len];
          rep.count_saturated = sat_seen;
          rep.pattern_overflow = ovf_seen;
          owed_reports.push_back(rep);
        end
      endcase
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("%0t: MISMATCH %s: got %0h, wanted %0h", $time, what, got, want);
    endtask

    // Compares one accepted result with the oldest report still owed.
    task check_result(dsc_pkg::out_t got);
      dsc_pkg::out_t want;
      if (owed_reports.size() == 0) begin
        report_mismatch("result with no report pending", got.occurrence_count, '0);
        return;
      end
      want = owed_reports.pop_front();
      if (got.occurrence_count !== want.occurrence_count) begin
        report_mismatch("occurrence_count", got.occurrence_count, want.occurrence_count);
      end
      if (got.count_saturated !== want.count_saturated) begin
        report_mismatch("count_saturated", 64'(got.count_saturated),
                        64'(want.count_saturated));
      end
      if (got.pattern_overflow !== want.pattern_overflow) begin
        report_mismatch("pattern_overflow", 64'(got.pattern_overflow),
                        64'(want.pattern_overflow));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  dsc_pkg::in_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  dsc_pkg::out_t out_data_o;

  occurrence_scoreboard sb = new();
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  bit send_no_gap = 1'b0;
  bit recv_no_stall = 1'b0;

  distinct_subsequence_counter #(
    .MAX_PATTERN(MaxPattern),
    .COUNT_BITS(CountBits)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: stall a random number of cycles after every accepted result, or none while no-stall mode is on.
  initial begin
    int unsigned hold;
    hold = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(out_data_o);
        if ($urandom_range(0, 19) == 0) recv_no_stall = !recv_no_stall;
        hold = recv_no_stall ? 0 : $urandom_range(0, MaxGap);
      end
      out_stall_i <= (hold != 0);
      if (hold != 0) hold--;
    end
  end

  function automatic logic [dsc_pkg::SymbolW-1:0] pick_sym(logic [dsc_pkg::SymbolW-1:0] base,
                                                           int unsigned span);
    return base + dsc_pkg::SymbolW'($urandom_range(0, span - 1));
  endfunction

  function automatic logic [dsc_pkg::SymbolW-1:0] rand_sym();
    return dsc_pkg::SymbolW'($urandom);
  endfunction

  // Presents one transaction after a random gap and waits until it is taken.
  task automatic send_item(logic [dsc_pkg::OpcodeW-1:0] op, logic [dsc_pkg::SymbolW-1:0] sym);
    dsc_pkg::in_t item;
    int unsigned gap;
    item.opcode = op;
    item.symbol = sym;
    gap = send_no_gap ? 0 : $urandom_range(0, MaxGap);
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_transaction(item);
    items_sent++;
  endtask

  // One random case: a pattern, usually after a clear, and text with reports; or random noise.
  task automatic run_case(case_kind_e kind);
    logic [dsc_pkg::SymbolW-1:0] base;
    logic [dsc_pkg::SymbolW-1:0] sym;
    int unsigned span;
    int unsigned plen;
    int unsigned tlen;
    base = rand_sym();
    case (kind)
      CaseSaturate: begin
        // A long run of one symbol against a 32-symbol pattern overflows 64 bits.
        send_item(dsc_pkg::OP_CLEAR, rand_sym());
        repeat (32) send_item(dsc_pkg::OP_APPEND, base);
        for (int i = 0; i < 80; i++) begin
          sym = ($urandom_range(0, 15) == 0) ? rand_sym() : base;
          send_item(dsc_pkg::OP_TEXT, sym);
          if (i % 10 == 9) send_item(dsc_pkg::OP_REPORT, rand_sym());
        end
      end
      CaseOverflow: begin
        send_item(dsc_pkg::OP_CLEAR, rand_sym());
        plen = MaxPattern + $urandom_range(1, 4);
        repeat (plen) send_item(dsc_pkg::OP_APPEND, pick_sym(base, 2));
        send_item(dsc_pkg::OP_REPORT, rand_sym());
        repeat (6) begin
          send_item(dsc_pkg::OP_TEXT, pick_sym(base, 2));
          if ($urandom_range(0, 1) == 0) send_item(dsc_pkg::OP_REPORT, rand_sym());
        end
        send_item(dsc_pkg::OP_REPORT, rand_sym());
      end
      CaseNoise: begin
        repeat ($urandom_range(6, 14)) begin
          send_item(dsc_pkg::OpcodeW'($urandom_range(0, 3)), rand_sym());
        end
      end
      default: begin
        // Mostly a fresh case; sometimes the previous one carries on.
        if ($urandom_range(0, 7) != 0) send_item(dsc_pkg::OP_CLEAR, rand_sym());
        span = $urandom_range(1, 4);
        plen = $urandom_range(0, 8);
        tlen = $urandom_range(0, 40);
        repeat (plen) send_item(dsc_pkg::OP_APPEND, pick_sym(base, span));
        for (int i = 0; i < tlen; i++) begin
          sym = ($urandom_range(0, 7) == 0) ? rand_sym() : pick_sym(base, span);
          send_item(dsc_pkg::OP_TEXT, sym);
          if ($urandom_range(0, 15) == 0) begin
            send_item(dsc_pkg::OP_APPEND, pick_sym(base, span));
          end
          if ($urandom_range(0, 7) == 0) send_item(dsc_pkg::OP_REPORT, rand_sym());
        end
        send_item(dsc_pkg::OP_REPORT, rand_sym());
      end
    endcase
  endtask

  initial begin
    int unsigned stop_at;
    int unsigned case_idx;
    int unsigned roll;
    case_kind_e kind;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty pattern, text before pattern, pattern after text,
    // extreme symbol values and a clear back to the empty state.
    send_item(dsc_pkg::OP_REPORT, 8'h00);
    send_item(dsc_pkg::OP_TEXT, 8'h00);
    send_item(dsc_pkg::OP_TEXT, 8'hFF);
    send_item(dsc_pkg::OP_REPORT, 8'hFF);
    send_item(dsc_pkg::OP_TEXT, 8'h5A);
    send_item(dsc_pkg::OP_APPEND, 8'h5A);
    send_item(dsc_pkg::OP_REPORT, 8'h00);
    send_item(dsc_pkg::OP_TEXT, 8'h5A);
    send_item(dsc_pkg::OP_REPORT, 8'h00);
    send_item(dsc_pkg::OP_CLEAR, 8'hFF);
    send_item(dsc_pkg::OP_APPEND, 8'hFF);
    send_item(dsc_pkg::OP_APPEND, 8'h00);
    send_item(dsc_pkg::OP_TEXT, 8'hFF);
    send_item(dsc_pkg::OP_TEXT, 8'h00);
    send_item(dsc_pkg::OP_TEXT, 8'hFF);
    send_item(dsc_pkg::OP_TEXT, 8'h00);
    send_item(dsc_pkg::OP_REPORT, 8'h00);
    send_item(dsc_pkg::OP_APPEND, 8'hFF);
    send_item(dsc_pkg::OP_TEXT, 8'hFF);
    send_item(dsc_pkg::OP_REPORT, 8'hFF);
    send_item(dsc_pkg::OP_CLEAR, 8'h00);
    send_item(dsc_pkg::OP_REPORT, 8'h00);

    // Random cases; saturation and pattern overflow are run first so both always occur.
    stop_at = items_sent + RandomItems;
    case_idx = 0;
    while (items_sent < stop_at) begin
      roll = $urandom_range(0, 15);
      if (case_idx == 0 || roll == 0) begin
        kind = CaseSaturate;
      end else if (case_idx == 1 || roll == 1) begin
        kind = CaseOverflow;
      end else if (roll < 4) begin
        kind = CaseNoise;
      end else begin
        kind = CaseTypical;
      end
      send_no_gap = ($urandom_range(0, 3) == 0);
      run_case(kind);
      case_idx++;
    end
    in_valid_i <= 1'b0;

    while (sb.owed_reports.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/dsc_pkg.sv
rtl/core/dsc_ram.sv
rtl/core/distinct_subsequence_counter.sv
dv/distinct_subsequence_counter_tb.sv
